/* design/fcou_pkg.sv */
// ----------------------------------------------------------------------------
// fcou_pkg
// Shared types, constants and tables of the fly camera orientation update.
// ----------------------------------------------------------------------------
package fcou_pkg;

    // Default parameter values
    localparam int ANGLE_FRAC_BITS_DEF = 7;
    localparam int TRIG_ITER_DEF       = 16;

    // Configuration register indexes
    localparam logic [7:0] REG_MOVE_SPEED = 8'd0;
    localparam logic [7:0] REG_MOUSE_GAIN = 8'd1;

    // Configuration reset values
    localparam logic [15:0] MOVE_SPEED_RST = 16'd1280;
    localparam logic [15:0] MOUSE_GAIN_RST = 16'd3277;

    // Shared multiplier widths
    localparam int MUL_AW = 25;
    localparam int MUL_BW = 17;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // Multiplier operation codes, issued in this order
    localparam logic [3:0] OP_VEL     = 4'd0;
    localparam logic [3:0] OP_YAW     = 4'd1;
    localparam logic [3:0] OP_PITCH   = 4'd2;
    localparam logic [3:0] OP_FX      = 4'd3;
    localparam logic [3:0] OP_FY      = 4'd4;
    localparam logic [3:0] OP_FZ      = 4'd5;
    localparam logic [3:0] OP_RX      = 4'd6;
    localparam logic [3:0] OP_RZ      = 4'd7;
    localparam logic [3:0] OP_MOVE_END = 4'd8;
    localparam logic [3:0] OP_CYCP    = 4'd8;
    localparam logic [3:0] OP_SYCP    = 4'd9;
    localparam logic [3:0] OP_CYSP    = 4'd10;
    localparam logic [3:0] OP_SYSP    = 4'd11;
    localparam logic [3:0] OP_VEC_END = 4'd12;

    // Q1.14 unit
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    // CORDIC constants: gain-compensated start and atan per step (2^32 per turn)
    localparam int CORDIC_MAX = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [0:23][29:0] ATAN_TBL = {
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    // Reciprocal of 45 at 2^24, for splitting the angle remainder
    localparam logic [18:0] RECIP45     = 19'd372828;
    localparam int          RECIP45_SH  = 24;

    // Fractional part table: floor(b * 2^k / 45) for b below 45
    function automatic logic [44:0][29:0] build_frac_tbl(input int k);
        logic [44:0][29:0] t;
        longint            n;
        for (int b = 0; b < 45; b++) begin
            n    = longint'(b) <<< k;
            t[b] = 30'(n / 45);
        end
        return t;
    endfunction

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_WRAP,
        ST_TRIG_YAW,
        ST_TRIG_PITCH,
        ST_VEC,
        ST_DONE
    } cam_state_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_SPLIT,
        CS_FRAC,
        CS_ITER,
        CS_DONE
    } trig_state_t;

endpackage

/* design/fcou_mul.sv */
// ----------------------------------------------------------------------------
// fcou_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module fcou_mul
    import fcou_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [MUL_AW-1:0] op_a,
    input  logic signed [MUL_BW-1:0] op_b,
    output logic signed [MUL_PW-1:0] prod
);

    logic signed [MUL_PW-1:0] prod_reg;

    // Register the product every cycle
    always_ff @(posedge aclk) begin
        prod_reg <= MUL_PW'(op_a) * MUL_PW'(op_b);
    end

    assign prod = prod_reg;

endmodule

/* design/fcou_cordic.sv */
// ----------------------------------------------------------------------------
// fcou_cordic
// Iterative sine and cosine in Q1.14 of an angle in 2^-AFB degree units.
// ----------------------------------------------------------------------------
module fcou_cordic
    import fcou_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [ANGLE_FRAC_BITS+8:0] angle,
    output logic                          done,
    output logic signed [15:0]            sin_q14,
    output logic signed [15:0]            cos_q14
);

    localparam int YW    = ANGLE_FRAC_BITS + 9;
    localparam int RW    = ANGLE_FRAC_BITS + 7;
    localparam int K     = 29 - ANGLE_FRAC_BITS;
    localparam int QUARTER = 90 << ANGLE_FRAC_BITS;
    localparam int FULL    = 360 << ANGLE_FRAC_BITS;
    localparam logic [44:0][29:0] FRAC_TBL = build_frac_tbl(K);

    trig_state_t state_reg, state_next;

    logic [1:0]          quad_reg;
    logic [RW-1:0]       rem_reg;
    logic                zero_reg;
    logic [RW-1:0]       whole_reg;
    logic signed [33:0]  x_reg, y_reg;
    logic signed [32:0]  z_reg;
    logic [4:0]          iter_reg;

    logic signed [YW:0]  wrapped;
    logic [YW-1:0]       mod_ang;
    logic [1:0]          quad;
    logic [RW-1:0]       rem;
    logic [RW+18:0]      recip_prod;
    logic [RW-1:0]       frac_idx_wide;
    logic [5:0]          frac_idx;
    logic signed [33:0]  xs, ys;
    logic signed [32:0]  atan_step;
    logic signed [33:0]  c_round, s_round;
    logic signed [15:0]  c_mag, s_mag;

    // Fold the angle into one turn, then split it into quadrant and remainder
    always_comb begin
        wrapped = (angle < 0) ? ((YW+1)'(angle) + (YW+1)'(FULL)) : (YW+1)'(angle);
        mod_ang = wrapped[YW-1:0];
        if (mod_ang >= YW'(3 * QUARTER)) begin
            quad = 2'd3;
            rem  = RW'(mod_ang - YW'(3 * QUARTER));
        end else if (mod_ang >= YW'(2 * QUARTER)) begin
            quad = 2'd2;
            rem  = RW'(mod_ang - YW'(2 * QUARTER));
        end else if (mod_ang >= YW'(QUARTER)) begin
            quad = 2'd1;
            rem  = RW'(mod_ang - YW'(QUARTER));
        end else begin
            quad = 2'd0;
            rem  = RW'(mod_ang);
        end
    end

    // Remainder divided by 45 through a reciprocal; the rest picks the fraction
    assign recip_prod    = (RW+19)'(rem_reg) * (RW+19)'(RECIP45);
    assign frac_idx_wide = rem_reg - RW'(whole_reg * RW'(45));
    assign frac_idx      = frac_idx_wide[5:0];

    // One rotation step
    assign xs        = x_reg >>> iter_reg;
    assign ys        = y_reg >>> iter_reg;
    assign atan_step = 33'(ATAN_TBL[iter_reg]);

    // Round to Q1.14 and clamp to [0, 1]
    always_comb begin
        c_round = (x_reg + 34'sd32768) >>> 16;
        s_round = (y_reg + 34'sd32768) >>> 16;
        if (zero_reg) begin
            c_mag = ONE_Q14;
            s_mag = 16'sd0;
        end else begin
            if (c_round < 0)
                c_mag = 16'sd0;
            else if (c_round > 34'sd16384)
                c_mag = ONE_Q14;
            else
                c_mag = c_round[15:0];
            if (s_round < 0)
                s_mag = 16'sd0;
            else if (s_round > 34'sd16384)
                s_mag = ONE_Q14;
            else
                s_mag = s_round[15:0];
        end
    end

    // Apply quadrant signs
    always_comb begin
        unique case (quad_reg)
            2'd0: begin
                cos_q14 = c_mag;
                sin_q14 = s_mag;
            end
            2'd1: begin
                cos_q14 = -s_mag;
                sin_q14 = c_mag;
            end
            2'd2: begin
                cos_q14 = -c_mag;
                sin_q14 = -s_mag;
            end
            default: begin
                cos_q14 = s_mag;
                sin_q14 = -c_mag;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and outputs
    always_comb begin
        state_next = state_reg;
        done       = 1'b0;
        unique case (state_reg)
            CS_IDLE: begin
                if (start)
                    state_next = CS_SPLIT;
            end
            CS_SPLIT: begin
                state_next = CS_FRAC;
            end
            CS_FRAC: begin
                state_next = zero_reg ? CS_DONE : CS_ITER;
            end
            CS_ITER: begin
                if (iter_reg == 5'(TRIG_ITERATIONS - 1))
                    state_next = CS_DONE;
            end
            CS_DONE: begin
                done       = 1'b1;
                state_next = CS_IDLE;
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // Datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            CS_IDLE: begin
                quad_reg <= quad;
                rem_reg  <= rem;
                zero_reg <= (rem == '0);
            end
            CS_SPLIT: begin
                whole_reg <= RW'(recip_prod >> RECIP45_SH);
            end
            CS_FRAC: begin
                z_reg    <= (33'(whole_reg) <<< K) + 33'(FRAC_TBL[frac_idx]);
                x_reg    <= CORDIC_GAIN;
                y_reg    <= 34'sd0;
                iter_reg <= 5'd0;
            end
            CS_ITER: begin
                if (z_reg >= 0) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_step;
                end else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_step;
                end
                iter_reg <= iter_reg + 5'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

/* design/fly_camera_orientation_update.sv */
// ----------------------------------------------------------------------------
// fly_camera_orientation_update
// First-person fly camera: moves the position per frame tick, applies mouse
// look to yaw and pitch, and recomputes the front and up vectors.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  s_*       in         s_valid / s_ready     delta_time keys mouse_locked dx dy
//  m_*       out        m_valid / m_ready     pos_xyz front_xyz up_xyz
//  cfg_*     in         cfg_valid / cfg_ready cfg_index cfg_data
//
//  A transaction's length is set by the shared multiplier sequence, the yaw
//  wrap loop and two passes of the CORDIC unit; it is shorter when the mouse
//  is not locked or an angle is a multiple of 90 degrees. s_ready is low
//  while a transaction is in work. A finished result waits in the output
//  register; the next transaction may start meanwhile. Reset is synchronous,
//  active low; cfg_ready stays high.
// ----------------------------------------------------------------------------
module fly_camera_orientation_update
    import fcou_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_delta_time,
    input  logic [5:0]         s_keys,
    input  logic               s_mouse_locked,
    input  logic signed [15:0] s_mouse_dx,
    input  logic signed [15:0] s_mouse_dy,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_pos_z,
    output logic signed [15:0] m_front_x,
    output logic signed [15:0] m_front_y,
    output logic signed [15:0] m_front_z,
    output logic signed [15:0] m_up_x,
    output logic signed [15:0] m_up_y,
    output logic signed [15:0] m_up_z,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int YW    = ANGLE_FRAC_BITS + 9;
    localparam int PW    = ANGLE_FRAC_BITS + 8;
    localparam int TW    = ANGLE_FRAC_BITS + 17;
    localparam int WW    = ANGLE_FRAC_BITS + 18;
    localparam int MSH   = 16 - ANGLE_FRAC_BITS;
    localparam int HALF  = 180 << ANGLE_FRAC_BITS;
    localparam int FULL  = 360 << ANGLE_FRAC_BITS;
    localparam int PLIM  = 89 << ANGLE_FRAC_BITS;
    localparam logic [3:0] WRAP_TOP = 4'd8;

    cam_state_t state_reg, state_next;

    logic [15:0]           move_speed_reg, mouse_gain_reg;
    logic [15:0]           dt_reg;
    logic [5:0]            keys_reg;
    logic                  locked_reg;
    logic signed [15:0]    dx_reg, dy_reg;

    logic signed [31:0]    pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [YW-1:0]  yaw_reg;
    logic signed [PW-1:0]  pitch_reg;
    logic signed [15:0]    front_x_reg, front_y_reg, front_z_reg;
    logic signed [15:0]    right_x_reg, right_z_reg;
    logic signed [15:0]    up_x_reg, up_y_reg, up_z_reg;

    logic [3:0]            op_reg;
    logic [23:0]           v_reg;
    logic signed [TW-1:0]  ty_reg, tp_reg;
    logic signed [25:0]    tfx_reg, tfy_reg, tfz_reg, trx_reg, trz_reg;
    logic [WW-1:0]         wrap_reg;
    logic [3:0]            wrap_k_reg;
    logic signed [15:0]    sy_reg, cy_reg, sp_reg, cp_reg;
    logic                  launched_reg;

    logic                  m_valid_reg;
    logic signed [31:0]    out_pos_x_reg, out_pos_y_reg, out_pos_z_reg;
    logic signed [15:0]    out_fx_reg, out_fy_reg, out_fz_reg;
    logic signed [15:0]    out_ux_reg, out_uy_reg, out_uz_reg;

    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [MUL_PW-1:0] prod;
    logic [3:0]               prev_op;
    logic signed [MUL_PW-1:0] mouse_rnd;
    logic signed [MUL_PW-1:0] vec_rnd;
    logic signed [15:0]       vec_q14;

    logic                     trig_start, trig_done;
    logic signed [YW-1:0]     trig_angle;
    logic signed [15:0]       trig_sin, trig_cos;

    logic signed [33:0]       sum_x, sum_y, sum_z;
    logic signed [33:0]       new_x, new_y, new_z;
    logic signed [31:0]       sat_x, sat_y, sat_z;
    logic signed [TW:0]       pitch_sum;
    logic signed [PW-1:0]     pitch_clamped;
    logic signed [WW:0]       wrap_init;
    logic [WW-1:0]            wrap_step;
    logic [WW-1:0]            wrap_sub;
    logic signed [YW:0]       yaw_wide;
    logic                     out_load;

    assign cfg_ready = 1'b1;
    assign prev_op   = op_reg - 4'd1;

    fcou_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    fcou_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (trig_start),
        .angle   (trig_angle),
        .done    (trig_done),
        .sin_q14 (trig_sin),
        .cos_q14 (trig_cos)
    );

    // Select multiplier operands for the issued operation
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (op_reg)
            OP_VEL:   begin mul_a = MUL_AW'(move_speed_reg); mul_b = MUL_BW'(dt_reg); end
            OP_YAW:   begin mul_a = MUL_AW'(dx_reg); mul_b = MUL_BW'(mouse_gain_reg); end
            OP_PITCH: begin mul_a = MUL_AW'(dy_reg); mul_b = MUL_BW'(mouse_gain_reg); end
            OP_FX:    begin mul_a = MUL_AW'(v_reg); mul_b = MUL_BW'(front_x_reg); end
            OP_FY:    begin mul_a = MUL_AW'(v_reg); mul_b = MUL_BW'(front_y_reg); end
            OP_FZ:    begin mul_a = MUL_AW'(v_reg); mul_b = MUL_BW'(front_z_reg); end
            OP_RX:    begin mul_a = MUL_AW'(v_reg); mul_b = MUL_BW'(right_x_reg); end
            OP_RZ:    begin mul_a = MUL_AW'(v_reg); mul_b = MUL_BW'(right_z_reg); end
            default: begin
                if (state_reg == ST_VEC) begin
                    unique case (op_reg)
                        OP_CYCP: begin mul_a = MUL_AW'(cy_reg); mul_b = MUL_BW'(cp_reg); end
                        OP_SYCP: begin mul_a = MUL_AW'(sy_reg); mul_b = MUL_BW'(cp_reg); end
                        OP_CYSP: begin mul_a = MUL_AW'(cy_reg); mul_b = MUL_BW'(sp_reg); end
                        OP_SYSP: begin mul_a = MUL_AW'(sy_reg); mul_b = MUL_BW'(sp_reg); end
                        default: begin end
                    endcase
                end
            end
        endcase
    end

    // Round the registered product for mouse terms and vector products
    assign mouse_rnd = (prod + (MUL_PW'(1) <<< (MSH - 1))) >>> MSH;
    assign vec_rnd   = (prod + MUL_PW'(8192)) >>> 14;
    assign vec_q14   = vec_rnd[15:0];

    // Sum the key terms per axis and saturate
    always_comb begin
        sum_x = '0;
        sum_y = '0;
        sum_z = '0;
        if (keys_reg[0]) begin
            sum_x = sum_x + 34'(tfx_reg);
            sum_y = sum_y + 34'(tfy_reg);
            sum_z = sum_z + 34'(tfz_reg);
        end
        if (keys_reg[1]) begin
            sum_x = sum_x - 34'(tfx_reg);
            sum_y = sum_y - 34'(tfy_reg);
            sum_z = sum_z - 34'(tfz_reg);
        end
        if (keys_reg[2]) begin
            sum_x = sum_x - 34'(trx_reg);
            sum_z = sum_z - 34'(trz_reg);
        end
        if (keys_reg[3]) begin
            sum_x = sum_x + 34'(trx_reg);
            sum_z = sum_z + 34'(trz_reg);
        end
        if (keys_reg[4])
            sum_y = sum_y + 34'($signed({1'b0, v_reg}));
        if (keys_reg[5])
            sum_y = sum_y - 34'($signed({1'b0, v_reg}));
        new_x = 34'(pos_x_reg) + sum_x;
        new_y = 34'(pos_y_reg) + sum_y;
        new_z = 34'(pos_z_reg) + sum_z;
        sat_x = (new_x > 34'sd2147483647) ? 32'sh7FFFFFFF :
                (new_x < -34'sd2147483648) ? 32'sh80000000 : new_x[31:0];
        sat_y = (new_y > 34'sd2147483647) ? 32'sh7FFFFFFF :
                (new_y < -34'sd2147483648) ? 32'sh80000000 : new_y[31:0];
        sat_z = (new_z > 34'sd2147483647) ? 32'sh7FFFFFFF :
                (new_z < -34'sd2147483648) ? 32'sh80000000 : new_z[31:0];
    end

    // Pitch update with clamp; yaw offset into a positive range for the wrap
    always_comb begin
        pitch_sum = (TW+1)'(pitch_reg) - (TW+1)'(tp_reg);
        if (pitch_sum > (TW+1)'(PLIM))
            pitch_clamped = PW'(PLIM);
        else if (pitch_sum < -(TW+1)'(PLIM))
            pitch_clamped = -PW'(PLIM);
        else
            pitch_clamped = pitch_sum[PW-1:0];
        wrap_init = (WW+1)'(yaw_reg) + (WW+1)'(ty_reg) + (WW+1)'(HALF)
                  + ((WW+1)'(FULL) <<< 7);
        wrap_step = WW'(FULL) << wrap_k_reg;
        wrap_sub  = (wrap_reg >= wrap_step) ? (wrap_reg - wrap_step) : wrap_reg;
        yaw_wide  = $signed({1'b0, wrap_sub[YW-1:0]}) - (YW+1)'(HALF);
    end

    assign trig_angle = (state_reg == ST_TRIG_YAW) ? yaw_reg : YW'(pitch_reg);

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake outputs
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        trig_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid)
                    state_next = ST_MUL;
            end
            ST_MUL: begin
                if (op_reg == OP_MOVE_END)
                    state_next = ST_ACC;
            end
            ST_ACC: begin
                state_next = locked_reg ? ST_WRAP : ST_TRIG_YAW;
            end
            ST_WRAP: begin
                if (wrap_k_reg == 4'd0)
                    state_next = ST_TRIG_YAW;
            end
            ST_TRIG_YAW: begin
                trig_start = !launched_reg;
                if (trig_done)
                    state_next = ST_TRIG_PITCH;
            end
            ST_TRIG_PITCH: begin
                trig_start = !launched_reg;
                if (trig_done)
                    state_next = ST_VEC;
            end
            ST_VEC: begin
                if (op_reg == OP_VEC_END)
                    state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_speed_reg <= MOVE_SPEED_RST;
            mouse_gain_reg <= MOUSE_GAIN_RST;
        end else if (cfg_valid) begin
            if (cfg_index == REG_MOVE_SPEED)
                move_speed_reg <= cfg_data;
            else if (cfg_index == REG_MOUSE_GAIN)
                mouse_gain_reg <= cfg_data;
        end
    end

    // Camera state and sequencing datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg    <= 32'sd0;
            pos_y_reg    <= 32'sd0;
            pos_z_reg    <= 32'sd196608;
            yaw_reg      <= -YW'(90 << ANGLE_FRAC_BITS);
            pitch_reg    <= '0;
            front_x_reg  <= 16'sd0;
            front_y_reg  <= 16'sd0;
            front_z_reg  <= -ONE_Q14;
            right_x_reg  <= ONE_Q14;
            right_z_reg  <= 16'sd0;
            up_x_reg     <= 16'sd0;
            up_y_reg     <= ONE_Q14;
            up_z_reg     <= 16'sd0;
            launched_reg <= 1'b0;
            op_reg       <= OP_VEL;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    // Capture the transaction
                    if (s_valid) begin
                        dt_reg     <= s_delta_time;
                        keys_reg   <= s_keys;
                        locked_reg <= s_mouse_locked;
                        dx_reg     <= s_mouse_dx;
                        dy_reg     <= s_mouse_dy;
                        op_reg     <= OP_VEL;
                    end
                end
                ST_MUL: begin
                    // Issue the next product, take the previous one
                    op_reg <= op_reg + 4'd1;
                    if (op_reg != OP_VEL) begin
                        unique case (prev_op)
                            OP_VEL:   v_reg   <= prod[31:8];
                            OP_YAW:   ty_reg  <= mouse_rnd[TW-1:0];
                            OP_PITCH: tp_reg  <= mouse_rnd[TW-1:0];
                            OP_FX:    tfx_reg <= prod[39:14];
                            OP_FY:    tfy_reg <= prod[39:14];
                            OP_FZ:    tfz_reg <= prod[39:14];
                            OP_RX:    trx_reg <= prod[39:14];
                            default:  trz_reg <= prod[39:14];
                        endcase
                    end
                end
                ST_ACC: begin
                    pos_x_reg <= sat_x;
                    pos_y_reg <= sat_y;
                    pos_z_reg <= sat_z;
                    if (locked_reg) begin
                        pitch_reg <= pitch_clamped;
                        wrap_reg  <= wrap_init[WW-1:0];
                    end
                    wrap_k_reg <= WRAP_TOP;
                end
                ST_WRAP: begin
                    // Strip the turn multiple FULL << wrap_k_reg per cycle when it fits
                    wrap_reg   <= wrap_sub;
                    wrap_k_reg <= wrap_k_reg - 4'd1;
                    if (wrap_k_reg == 4'd0)
                        yaw_reg <= yaw_wide[YW-1:0];
                end
                ST_TRIG_YAW: begin
                    if (trig_start)
                        launched_reg <= 1'b1;
                    if (trig_done) begin
                        sy_reg       <= trig_sin;
                        cy_reg       <= trig_cos;
                        launched_reg <= 1'b0;
                    end
                end
                ST_TRIG_PITCH: begin
                    if (trig_start)
                        launched_reg <= 1'b1;
                    if (trig_done) begin
                        sp_reg       <= trig_sin;
                        cp_reg       <= trig_cos;
                        launched_reg <= 1'b0;
                        op_reg       <= OP_CYCP;
                    end
                end
                ST_VEC: begin
                    // Rebuild the basis vectors
                    op_reg      <= op_reg + 4'd1;
                    front_y_reg <= sp_reg;
                    up_y_reg    <= cp_reg;
                    right_x_reg <= -sy_reg;
                    right_z_reg <= cy_reg;
                    if (op_reg != OP_CYCP) begin
                        unique case (prev_op)
                            OP_CYCP: front_x_reg <= vec_q14;
                            OP_SYCP: front_z_reg <= vec_q14;
                            OP_CYSP: up_x_reg    <= -vec_q14;
                            default: up_z_reg    <= -vec_q14;
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: load on completion, drop on acceptance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_pos_x_reg <= pos_x_reg;
            out_pos_y_reg <= pos_y_reg;
            out_pos_z_reg <= pos_z_reg;
            out_fx_reg    <= front_x_reg;
            out_fy_reg    <= front_y_reg;
            out_fz_reg    <= front_z_reg;
            out_ux_reg    <= up_x_reg;
            out_uy_reg    <= up_y_reg;
            out_uz_reg    <= up_z_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_pos_x   = out_pos_x_reg;
    assign m_pos_y   = out_pos_y_reg;
    assign m_pos_z   = out_pos_z_reg;
    assign m_front_x = out_fx_reg;
    assign m_front_y = out_fy_reg;
    assign m_front_z = out_fz_reg;
    assign m_up_x    = out_ux_reg;
    assign m_up_y    = out_uy_reg;
    assign m_up_z    = out_uz_reg;

endmodule

/* verif/fly_camera_orientation_update_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fly_camera_orientation_update_tb
// Drives frame ticks with random key, mouse and timing content through the
// camera update, predicts position, front and up vectors in fixed point and
// compares every result transaction field by field, under random stalls.
// ----------------------------------------------------------------------------
module fly_camera_orientation_update_tb
    import fcou_pkg::*;
;

    localparam int AFB      = 7;
    localparam int ITERS    = 16;
    localparam int N_RAND   = 1350;
    localparam int WD_LIMIT = 20000;
    localparam int DRAIN    = 100;

    // Register index that the block does not implement
    localparam logic [7:0] REG_UNKNOWN = 8'd7;

    localparam longint QUARTER_A = 90 <<< AFB;
    localparam longint HALF_A    = 180 <<< AFB;
    localparam longint FULL_A    = 360 <<< AFB;
    localparam longint PITCH_MAX = 89 <<< AFB;

    typedef struct packed {
        logic [15:0] dt;
        logic [5:0]  keys;
        logic        locked;
        logic [15:0] dx;
        logic [15:0] dy;
    } tick_t;

    typedef struct packed {
        logic [31:0] px, py, pz;
        logic [15:0] fx, fy, fz, ux, uy, uz;
    } pose_t;

    typedef struct {
        tick_t tick;
        logic  chk;
        pose_t pose;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [15:0] s_delta_time = '0;
    logic [5:0] s_keys = '0;
    logic s_mouse_locked = 1'b0;
    logic signed [15:0] s_mouse_dx = '0;
    logic signed [15:0] s_mouse_dy = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_pos_x, m_pos_y, m_pos_z;
    logic signed [15:0] m_front_x, m_front_y, m_front_z, m_up_x, m_up_y, m_up_z;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    fly_camera_orientation_update u_top (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Camera state of the predictor
    longint speed_q, gain_q;
    longint cam_px, cam_py, cam_pz, cam_yaw, cam_pitch;
    longint cam_fx, cam_fy, cam_fz, cam_rx, cam_rz, cam_ux, cam_uy, cam_uz;

    pose_t pose_q[$];
    logic  fixed_q[$];
    pose_t typed_q[$];
    int    errors = 0;
    int    idle_cycles = 0;
    bit    wd_hit = 1'b0;

    function automatic longint fshift(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint wrap_turn(longint a);
        longint m;
        m = a % FULL_A;
        return (m < 0) ? m + FULL_A : m;
    endfunction

    function automatic longint q14_clamp(longint v30);
        longint r;
        r = fshift(v30 + 32768, 16);
        if (r < 0) r = 0;
        if (r > 16384) r = 16384;
        return r;
    endfunction

    task automatic sine_cosine(input longint ang, output longint s_o, output longint c_o);
        longint m, q, r, c, s, x, y, z, xs, ys;
        m = wrap_turn(ang);
        q = m / QUARTER_A;
        r = m % QUARTER_A;
        c = 16384;
        s = 0;
        if (r != 0) begin
            x = CORDIC_GAIN;
            y = 0;
            z = (r <<< (32 - AFB)) / 360;
            for (int i = 0; i < ITERS; i++) begin
                xs = fshift(x, i);
                ys = fshift(y, i);
                if (z >= 0) begin
                    x -= ys; y += xs; z -= longint'(ATAN_TBL[i]);
                end else begin
                    x += ys; y -= xs; z += longint'(ATAN_TBL[i]);
                end
            end
            c = q14_clamp(x);
            s = q14_clamp(y);
        end
        case (q & 3)
            0: begin c_o = c;  s_o = s;  end
            1: begin c_o = -s; s_o = c;  end
            2: begin c_o = -c; s_o = -s; end
            default: begin c_o = s; s_o = -c; end
        endcase
    endtask

    function automatic longint mul14(longint a, longint b);
        return fshift(a * b + 8192, 14);
    endfunction

    task automatic refresh_vectors();
        longint sy, cy, sp, cp;
        sine_cosine(cam_yaw, sy, cy);
        sine_cosine(cam_pitch, sp, cp);
        cam_fx = mul14(cy, cp);
        cam_fy = sp;
        cam_fz = mul14(sy, cp);
        cam_rx = -sy;
        cam_rz = cy;
        cam_ux = -mul14(cy, sp);
        cam_uy = cp;
        cam_uz = -mul14(sy, sp);
    endtask

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint look_term(longint cnt);
        return fshift(cnt * gain_q + (64'sd1 <<< (15 - AFB)), 16 - AFB);
    endfunction

    task automatic camera_reset();
        speed_q = MOVE_SPEED_RST;
        gain_q = MOUSE_GAIN_RST;
        cam_px = 0; cam_py = 0; cam_pz = 196608;
        cam_yaw = -QUARTER_A;
        cam_pitch = 0;
        refresh_vectors();
    endtask

    // Advance the camera by one frame tick and return the new pose
    task automatic camera_step(input tick_t t, output pose_t p);
        longint v, ax, ay, az, pit;
        v = (speed_q * longint'(t.dt)) >>> 8;
        ax = 0; ay = 0; az = 0;
        if (t.keys[0]) begin
            ax += fshift(v * cam_fx, 14); ay += fshift(v * cam_fy, 14);
            az += fshift(v * cam_fz, 14);
        end
        if (t.keys[1]) begin
            ax -= fshift(v * cam_fx, 14); ay -= fshift(v * cam_fy, 14);
            az -= fshift(v * cam_fz, 14);
        end
        if (t.keys[2]) begin
            ax -= fshift(v * cam_rx, 14); az -= fshift(v * cam_rz, 14);
        end
        if (t.keys[3]) begin
            ax += fshift(v * cam_rx, 14); az += fshift(v * cam_rz, 14);
        end
        if (t.keys[4]) ay += v;
        if (t.keys[5]) ay -= v;
        cam_px = sat32(cam_px + ax);
        cam_py = sat32(cam_py + ay);
        cam_pz = sat32(cam_pz + az);
        if (t.locked) begin
            pit = cam_pitch - look_term(longint'($signed(t.dy)));
            cam_yaw = wrap_turn(cam_yaw + look_term(longint'($signed(t.dx))) + HALF_A)
                      - HALF_A;
            if (pit > PITCH_MAX) pit = PITCH_MAX;
            if (pit < -PITCH_MAX) pit = -PITCH_MAX;
            cam_pitch = pit;
        end
        refresh_vectors();
        p = {cam_px[31:0], cam_py[31:0], cam_pz[31:0], cam_fx[15:0], cam_fy[15:0],
             cam_fz[15:0], cam_ux[15:0], cam_uy[15:0], cam_uz[15:0]};
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // Send one frame tick, queueing the predicted pose; valid stays high
    // into the next tick when there is no gap
    task automatic send_tick(input tick_t t, input logic chk, input pose_t typed);
        pose_t p;
        int    g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_delta_time <= t.dt;
        s_keys <= t.keys;
        s_mouse_locked <= t.locked;
        s_mouse_dx <= t.dx;
        s_mouse_dy <= t.dy;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        camera_step(t, p);
        pose_q.push_back(p);
        fixed_q.push_back(chk);
        typed_q.push_back(typed);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_MOVE_SPEED) speed_q = val;
        else if (idx == REG_MOUSE_GAIN) gain_q = val;
        @(posedge aclk);
    endtask

    // Drop valid, wait until every result is back, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (pose_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    function automatic tick_t rand_tick();
        tick_t t;
        int r;
        r = $urandom_range(0, 9);
        t.dt = (r < 7) ? 16'($urandom_range(0, 4000)) : 16'($urandom);
        t.keys = 6'($urandom);
        t.locked = ($urandom_range(0, 3) != 0);
        r = $urandom_range(0, 9);
        t.dx = (r < 6) ? 16'($urandom_range(0, 400) - 200) : 16'($urandom);
        r = $urandom_range(0, 9);
        t.dy = (r < 6) ? 16'($urandom_range(0, 400) - 200) : 16'($urandom);
        return t;
    endfunction

    // Result side: random stalls and comparison against the oldest prediction
    always @(posedge aclk) begin
        pose_t got, want;
        logic  chk;
        pose_t typed;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_pos_x, m_pos_y, m_pos_z, m_front_x, m_front_y, m_front_z,
                       m_up_x, m_up_y, m_up_z};
                if (pose_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = pose_q.pop_front();
                    chk = fixed_q.pop_front();
                    typed = typed_q.pop_front();
                    if (chk && typed != want) begin
                        $display("%0t: typed row %h disagrees with predictor %h",
                                 $time, typed, want);
                        errors++;
                    end
                    if (got.px != want.px) begin
                        $display("%0t: pos_x exp %h got %h", $time, want.px, got.px);
                        errors++;
                    end
                    if (got.py != want.py) begin
                        $display("%0t: pos_y exp %h got %h", $time, want.py, got.py);
                        errors++;
                    end
                    if (got.pz != want.pz) begin
                        $display("%0t: pos_z exp %h got %h", $time, want.pz, got.pz);
                        errors++;
                    end
                    if (got.fx != want.fx) begin
                        $display("%0t: front_x exp %h got %h", $time, want.fx, got.fx);
                        errors++;
                    end
                    if (got.fy != want.fy) begin
                        $display("%0t: front_y exp %h got %h", $time, want.fy, got.fy);
                        errors++;
                    end
                    if (got.fz != want.fz) begin
                        $display("%0t: front_z exp %h got %h", $time, want.fz, got.fz);
                        errors++;
                    end
                    if (got.ux != want.ux) begin
                        $display("%0t: up_x exp %h got %h", $time, want.ux, got.ux);
                        errors++;
                    end
                    if (got.uy != want.uy) begin
                        $display("%0t: up_y exp %h got %h", $time, want.uy, got.uy);
                        errors++;
                    end
                    if (got.uz != want.uz) begin
                        $display("%0t: up_z exp %h got %h", $time, want.uz, got.uz);
                        errors++;
                    end
                end
            end
            if ($urandom_range(0, 199) == 0) m_ready <= 1'b0;
            else if ($urandom_range(0, 3) == 0) m_ready <= ($urandom_range(0, 2) != 0);
            else if (!m_ready && $urandom_range(0, 19) != 0) m_ready <= m_ready;
            else m_ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no accepted transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || (!s_valid && pose_q.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) wd_hit <= 1'b1;
    end

    initial begin
        @(posedge wd_hit);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    dir_row_t dir_rows[$];
    pose_t    no_pose;

    initial begin
        tick_t t;
        no_pose = '0;
        // Typed rows: still frames keep the reset pose
        dir_rows.push_back('{'{16'd0, 6'h3F, 1'b0, 16'h7FFF, 16'h8000}, 1'b1,
            '{32'd0, 32'd0, 32'd196608, 16'd0, 16'd0, -16'sd16384,
              16'd0, 16'd16384, 16'd0}});
        dir_rows.push_back('{'{16'hFFFF, 6'h03, 1'b0, 16'h0, 16'h0}, 1'b1,
            '{32'd0, 32'd0, 32'd196608, 16'd0, 16'd0, -16'sd16384,
              16'd0, 16'd16384, 16'd0}});
        dir_rows.push_back('{'{16'hFFFF, 6'h0C, 1'b1, 16'h0, 16'h0}, 1'b1,
            '{32'd0, 32'd0, 32'd196608, 16'd0, 16'd0, -16'sd16384,
              16'd0, 16'd16384, 16'd0}});
        // Predictor rows: each key, extremes, pitch clamp, huge yaw turns
        dir_rows.push_back('{'{16'hFFFF, 6'h01, 1'b0, 16'h0, 16'h0}, 1'b0, no_pose});
        dir_rows.push_back('{'{16'hFFFF, 6'h02, 1'b0, 16'h0, 16'h0}, 1'b0, no_pose});
        dir_rows.push_back('{'{16'hFFFF, 6'h04, 1'b0, 16'h0, 16'h0}, 1'b0, no_pose});
        dir_rows.push_back('{'{16'hFFFF, 6'h08, 1'b0, 16'h0, 16'h0}, 1'b0, no_pose});
        dir_rows.push_back('{'{16'hFFFF, 6'h10, 1'b0, 16'h0, 16'h0}, 1'b0, no_pose});
        dir_rows.push_back('{'{16'hFFFF, 6'h20, 1'b0, 16'h0, 16'h0}, 1'b0, no_pose});
        dir_rows.push_back('{'{16'h1000, 6'h00, 1'b1, 16'h7FFF, 16'h7FFF}, 1'b0, no_pose});
        dir_rows.push_back('{'{16'h1000, 6'h00, 1'b1, 16'h8000, 16'h8000}, 1'b0, no_pose});
        dir_rows.push_back('{'{16'h2000, 6'h0F, 1'b1, 16'h0123, 16'hFF00}, 1'b0, no_pose});
        dir_rows.push_back('{'{16'h2000, 6'h15, 1'b1, 16'hFF38, 16'h0040}, 1'b0, no_pose});
        dir_rows.push_back('{'{16'h0001, 6'h2A, 1'b0, 16'h7FFF, 16'h8000}, 1'b0, no_pose});

        camera_reset();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) send_tick(dir_rows[i].tick, dir_rows[i].chk, dir_rows[i].pose);
        drain();

        // Full speed upward until the position saturates, then back down
        write_reg(REG_MOVE_SPEED, 16'hFFFF);
        write_reg(REG_MOUSE_GAIN, 16'hFFFF);
        write_reg(REG_UNKNOWN, 16'h1234);
        for (int i = 0; i < 130; i++)
            send_tick('{16'hFFFF, 6'h10, 1'b1, 16'($urandom), 16'($urandom)}, 1'b0, no_pose);
        for (int i = 0; i < 20; i++)
            send_tick('{16'hFFFF, 6'h21, 1'b0, 16'h0, 16'h0}, 1'b0, no_pose);
        drain();

        // Random phases under several register settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_reg(REG_MOVE_SPEED, 16'd0); write_reg(REG_MOUSE_GAIN, 16'd0); end
                1: begin write_reg(REG_MOVE_SPEED, MOVE_SPEED_RST);
                         write_reg(REG_MOUSE_GAIN, MOUSE_GAIN_RST); end
                default: begin write_reg(REG_MOVE_SPEED, 16'($urandom));
                               write_reg(REG_MOUSE_GAIN, 16'($urandom)); end
            endcase
            for (int i = 0; i < N_RAND / 5; i++) begin
                t = rand_tick();
                send_tick(t, 1'b0, no_pose);
            end
            drain();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
